[rtl/qfts_pkg.sv]
// Shared types, constants and the control-store contents of the two-stack queue.
// No dependencies; used by qfts_seq and queue_from_two_stacks_unit.
package qfts_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UPC_W  = 3;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_ALWAYS,
    C_IN_FULL,
    C_OUT_NZ,
    C_IN_Z,
    C_IN_NZ
  } cond_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_PUSH,
    A_OVF,
    A_UNF,
    A_MV_RD,
    A_MV_WR,
    A_POP_RD,
    A_POP_OUT
  } act_e;

  localparam upc_t U_IDLE    = 3'd0;
  localparam upc_t U_PUSH    = 3'd1;
  localparam upc_t U_POP     = 3'd2;
  localparam upc_t U_CHK     = 3'd3;
  localparam upc_t U_MV_WR   = 3'd4;
  localparam upc_t U_MV_NEXT = 3'd5;
  localparam upc_t U_POP_OUT = 3'd6;

  typedef struct packed {
    cond_e cond;
    upc_t  tgt_t;
    act_e  act_t;
    upc_t  tgt_f;
    act_e  act_f;
  } uword_t;

  typedef struct packed {
    logic start;
    logic op_pop;
    logic in_full;
    logic in_zero;
    logic out_zero;
  } qfts_flags_t;

  typedef struct packed {
    act_e act;
    logic busy;
  } qfts_ctrl_t;

  function automatic uword_t ucode_rom(upc_t addr);
    uword_t w;
    unique case (addr)
      U_IDLE:    w = '{C_IDLE,    U_POP,     A_ACCEPT, U_PUSH,    A_ACCEPT};
      U_PUSH:    w = '{C_IN_FULL, U_IDLE,    A_OVF,    U_IDLE,    A_PUSH};
      U_POP:     w = '{C_OUT_NZ,  U_POP_OUT, A_POP_RD, U_CHK,     A_NONE};
      U_CHK:     w = '{C_IN_Z,    U_IDLE,    A_UNF,    U_MV_WR,   A_MV_RD};
      U_MV_WR:   w = '{C_ALWAYS,  U_MV_NEXT, A_MV_WR,  U_MV_NEXT, A_MV_WR};
      U_MV_NEXT: w = '{C_IN_NZ,   U_MV_WR,   A_MV_RD,  U_POP_OUT, A_POP_RD};
      U_POP_OUT: w = '{C_ALWAYS,  U_IDLE,    A_POP_OUT, U_IDLE,   A_POP_OUT};
      default:   w = '{C_ALWAYS,  U_IDLE,    A_NONE,   U_IDLE,    A_NONE};
    endcase
    return w;
  endfunction

endpackage

[rtl/queue_from_two_stacks_unit.sv]
// Top level: FIFO built from two stacks, microcoded control over a small datapath.
// Depends on qfts_pkg and qfts_seq.
//
//  channel | signals                         | handshake
//  --------+---------------------------------+---------------------------
//  input   | op_i, value_i                   | start high while busy low
//  result  | result_value_o, status_o        | done_o, one cycle, no stall
//
// A push is accepted and then written; a pop with a non-empty output stack is
// accepted, read and returned; a pop that refills first moves every input item,
// one stack-memory access per step of the sequencer. Underflow is flagged once both stacks are found empty.
// Reset clears the step counter, both stack counts and done_o; stack
// contents are undefined until written. The receiver cannot stall.
module queue_from_two_stacks_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic signed [qfts_pkg::WORD_W-1:0] value_i,
  output logic                              done_o,
  output logic signed [qfts_pkg::WORD_W-1:0] result_value_o,
  output logic [1:0]                        status_o
);
  import qfts_pkg::*;

  logic [WORD_W-1:0] in_stack  [DEPTH];
  logic [WORD_W-1:0] out_stack [DEPTH];

  cnt_t              in_cnt_q, in_cnt_d;
  cnt_t              out_cnt_q, out_cnt_d;
  cnt_t              in_cnt_dec, out_cnt_dec;
  logic [WORD_W-1:0] value_q;
  logic [WORD_W-1:0] rdata_q;
  logic              done_q, done_d;
  logic [WORD_W-1:0] result_q, result_d;
  status_e           status_q, status_d;
  qfts_flags_t       flags;
  qfts_ctrl_t        ctrl;

  assign in_cnt_dec  = in_cnt_q - CNT_W'(1);
  assign out_cnt_dec = out_cnt_q - CNT_W'(1);

  assign flags.start    = start;
  assign flags.op_pop   = op_i;
  assign flags.in_full  = (in_cnt_q == CNT_W'(DEPTH));
  assign flags.in_zero  = (in_cnt_q == '0);
  assign flags.out_zero = (out_cnt_q == '0);

  qfts_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign busy = ctrl.busy;

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    done_d    = 1'b0;
    result_d  = result_q;
    status_d  = status_q;
    unique case (ctrl.act)
      A_PUSH: begin
        in_cnt_d = in_cnt_q + CNT_W'(1);
        done_d   = 1'b1;
        result_d = '0;
        status_d = ST_OK;
      end
      A_OVF: begin
        done_d   = 1'b1;
        result_d = '0;
        status_d = ST_OVERFLOW;
      end
      A_UNF: begin
        done_d   = 1'b1;
        result_d = '1;
        status_d = ST_UNDERFLOW;
      end
      A_MV_RD:   in_cnt_d  = in_cnt_dec;
      A_MV_WR:   out_cnt_d = out_cnt_q + CNT_W'(1);
      A_POP_RD:  out_cnt_d = out_cnt_dec;
      A_POP_OUT: begin
        done_d   = 1'b1;
        result_d = rdata_q;
        status_d = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
    if (ctrl.act == A_ACCEPT) begin
      value_q <= value_i;
    end
  end

  // stack memories, one access per step
  always_ff @(posedge clk_i) begin
    if (ctrl.act == A_PUSH) begin
      in_stack[in_cnt_q[ADDR_W-1:0]] <= value_q;
    end
    if (ctrl.act == A_MV_RD) begin
      rdata_q <= in_stack[in_cnt_dec[ADDR_W-1:0]];
    end else if (ctrl.act == A_POP_RD) begin
      rdata_q <= out_stack[out_cnt_dec[ADDR_W-1:0]];
    end
    if (ctrl.act == A_MV_WR) begin
      out_stack[out_cnt_q[ADDR_W-1:0]] <= rdata_q;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  a_in_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q <= CNT_W'(DEPTH))
    else $error("input count out of range");
  a_out_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= CNT_W'(DEPTH))
    else $error("output count out of range");
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("item result while sequencer busy");
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_UNDERFLOW) |-> (in_cnt_q == '0 && out_cnt_q == '0))
    else $error("underflow with stored items");
  a_refill_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.act == A_MV_RD && $past(ctrl.act) != A_MV_WR) |-> (out_cnt_q == '0))
    else $error("refill started with non-empty output stack");

endmodule

[rtl/qfts_seq.sv]
// Microcode sequencer: step counter, control-store lookup and branch evaluation.
// Depends on qfts_pkg.
module qfts_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qfts_pkg::qfts_flags_t flags_i,
  output qfts_pkg::qfts_ctrl_t  ctrl_o
);
  import qfts_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    uw = ucode_rom(upc_q);
    unique case (uw.cond)
      C_IDLE:    taken = flags_i.op_pop;
      C_ALWAYS:  taken = 1'b1;
      C_IN_FULL: taken = flags_i.in_full;
      C_OUT_NZ:  taken = !flags_i.out_zero;
      C_IN_Z:    taken = flags_i.in_zero;
      C_IN_NZ:   taken = !flags_i.in_zero;
      default:   taken = 1'b1;
    endcase
    upc_d       = taken ? uw.tgt_t : uw.tgt_f;
    ctrl_o.act  = taken ? uw.act_t : uw.act_f;
    ctrl_o.busy = (upc_q != U_IDLE);
    if (uw.cond == C_IDLE && !flags_i.start) begin
      upc_d      = upc_q;
      ctrl_o.act = A_NONE;
    end
  end

  a_idle_only_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.act == A_ACCEPT) |-> (upc_q == U_IDLE))
    else $error("accept outside idle step");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.act == A_ACCEPT) |=> (upc_q == U_PUSH || upc_q == U_POP))
    else $error("bad dispatch after accept");
  a_move_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.act == A_MV_RD) |=> (ctrl_o.act == A_MV_WR))
    else $error("move read not followed by write");

endmodule
